/* src/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: shared package
// Widths, register indexes, configuration and stage types.
// ----------------------------------------------------------------------------
package pdc_pkg;

   localparam int SampleWidth  = 16;
   localparam int GainFracBits = 8;
   localparam int GainWidth    = 16;
   localparam int LimitWidth   = 15;
   localparam int IntegWidth   = LimitWidth + 1;
   localparam int ErrWidth     = SampleWidth + 1;
   localparam int DiffWidth    = ErrWidth + 1;
   localparam int ProdWidth    = GainWidth + DiffWidth;
   localparam int TermWidth    = ProdWidth - GainFracBits;
   localparam int SumWidth     = TermWidth + 2;
   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   typedef enum logic {
      OP_COMPUTE = 1'b0,
      OP_CLEAR   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      REG_PROP_GAIN       = 3'd0,
      REG_INTEG_GAIN      = 3'd1,
      REG_DERIV_GAIN      = 3'd2,
      REG_INTEG_LIMIT     = 3'd3,
      REG_OUTPUT_LIMIT    = 3'd4,
      REG_DEADBAND_WIDTH  = 3'd5,
      REG_DEADBAND_ENABLE = 3'd6,
      REG_ZERO_IN_BAND    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [GainWidth-1:0] prop_gain;
      logic signed [GainWidth-1:0] integ_gain;
      logic signed [GainWidth-1:0] deriv_gain;
      logic [LimitWidth-1:0]       integ_limit;
      logic [LimitWidth-1:0]       output_limit;
      logic [LimitWidth-1:0]       deadband_width;
      logic                        deadband_enable;
      logic                        zero_in_band;
   } cfg_type;

   typedef struct packed {
      logic                        clear_integ;
      logic                        zero_out;
      logic signed [TermWidth-1:0] p_term;
      logic signed [TermWidth-1:0] i_term;
      logic signed [TermWidth-1:0] d_term;
   } stage_type;

endpackage

/* src/pdc_if.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: channel interfaces
// Request channel carries one control item, response channel one drive item.
// ----------------------------------------------------------------------------
interface pdc_req_if;
   logic                                     valid;
   logic                                     ready;
   pdc_pkg::op_type                          op;
   logic signed [pdc_pkg::SampleWidth-1:0]   reference;
   logic signed [pdc_pkg::SampleWidth-1:0]   measured;

   modport source (output valid, output op, output reference, output measured, input ready);
   modport sink (input valid, input op, input reference, input measured, output ready);
endinterface

interface pdc_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pdc_pkg::SampleWidth-1:0]   drive;

   modport source (output valid, output drive, input ready);
   modport sink (input valid, input drive, output ready);
endinterface

/* src/pdc_csr.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: configuration registers
// APB-style register file holding gains, limits and deadband controls.
// ----------------------------------------------------------------------------
module pdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pdc_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [pdc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [pdc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready,
   output pdc_pkg::cfg_type                    cfg
);

   pdc_pkg::cfg_type       cfg_ff;
   pdc_pkg::cfg_type       cfg_in;
   pdc_pkg::csr_index_type index;
   logic                   write_en;

   assign index    = pdc_pkg::csr_index_type'(paddr[pdc_pkg::CsrAddrWidth-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            pdc_pkg::REG_PROP_GAIN:
               cfg_in.prop_gain = pwdata[pdc_pkg::GainWidth-1:0];
            pdc_pkg::REG_INTEG_GAIN:
               cfg_in.integ_gain = pwdata[pdc_pkg::GainWidth-1:0];
            pdc_pkg::REG_DERIV_GAIN:
               cfg_in.deriv_gain = pwdata[pdc_pkg::GainWidth-1:0];
            pdc_pkg::REG_INTEG_LIMIT:
               cfg_in.integ_limit = pwdata[pdc_pkg::LimitWidth-1:0];
            pdc_pkg::REG_OUTPUT_LIMIT:
               cfg_in.output_limit = pwdata[pdc_pkg::LimitWidth-1:0];
            pdc_pkg::REG_DEADBAND_WIDTH:
               cfg_in.deadband_width = pwdata[pdc_pkg::LimitWidth-1:0];
            pdc_pkg::REG_DEADBAND_ENABLE:
               cfg_in.deadband_enable = pwdata[0];
            pdc_pkg::REG_ZERO_IN_BAND:
               cfg_in.zero_in_band = pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         pdc_pkg::REG_PROP_GAIN:
            prdata = pdc_pkg::CsrDataWidth'($unsigned(cfg_ff.prop_gain));
         pdc_pkg::REG_INTEG_GAIN:
            prdata = pdc_pkg::CsrDataWidth'($unsigned(cfg_ff.integ_gain));
         pdc_pkg::REG_DERIV_GAIN:
            prdata = pdc_pkg::CsrDataWidth'($unsigned(cfg_ff.deriv_gain));
         pdc_pkg::REG_INTEG_LIMIT:
            prdata = pdc_pkg::CsrDataWidth'(cfg_ff.integ_limit);
         pdc_pkg::REG_OUTPUT_LIMIT:
            prdata = pdc_pkg::CsrDataWidth'(cfg_ff.output_limit);
         pdc_pkg::REG_DEADBAND_WIDTH:
            prdata = pdc_pkg::CsrDataWidth'(cfg_ff.deadband_width);
         pdc_pkg::REG_DEADBAND_ENABLE:
            prdata = pdc_pkg::CsrDataWidth'(cfg_ff.deadband_enable);
         pdc_pkg::REG_ZERO_IN_BAND:
            prdata = pdc_pkg::CsrDataWidth'(cfg_ff.zero_in_band);
         default: prdata = '0;
      endcase
   end

endmodule

/* src/pdc_front.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: error and gain stage
// Forms the error, applies the deadband, keeps the previous error and
// registers the three scaled gain products.
// ----------------------------------------------------------------------------
module pdc_front (
   input  logic                clock,
   input  logic                reset,
   pdc_req_if.sink             req_ch,
   input  pdc_pkg::cfg_type    cfg,
   input  logic                stage_ready,
   output logic                stage_valid,
   output pdc_pkg::stage_type  stage
);

   logic signed [pdc_pkg::ErrWidth-1:0]  prev_err_ff;
   logic signed [pdc_pkg::ErrWidth-1:0]  prev_err_in;
   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   pdc_pkg::stage_type                   s1_ff;
   pdc_pkg::stage_type                   s1_in;

   logic                                 accept;
   logic signed [pdc_pkg::ErrWidth-1:0]  err_raw;
   logic signed [pdc_pkg::DiffWidth-1:0] err_wide;
   logic signed [pdc_pkg::DiffWidth-1:0] db_pos;
   logic signed [pdc_pkg::DiffWidth-1:0] db_neg;
   logic signed [pdc_pkg::DiffWidth-1:0] ref_wide;
   logic signed [pdc_pkg::DiffWidth-1:0] prev_wide;
   logic signed [pdc_pkg::DiffWidth-1:0] err_adj;
   logic signed [pdc_pkg::ErrWidth-1:0]  err_new;
   logic signed [pdc_pkg::DiffWidth-1:0] err_diff;
   logic                                 above;
   logic                                 below;
   logic                                 in_band;
   logic                                 ref_in_band;
   logic                                 prev_out_band;
   logic signed [pdc_pkg::ProdWidth-1:0] p_prod;
   logic signed [pdc_pkg::ProdWidth-1:0] i_prod;
   logic signed [pdc_pkg::ProdWidth-1:0] d_prod;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || stage_ready;
   assign stage_valid  = s1_valid_ff;
   assign stage        = s1_ff;

   always_comb begin
      err_raw   = pdc_pkg::ErrWidth'(req_ch.reference) - pdc_pkg::ErrWidth'(req_ch.measured);
      err_wide  = pdc_pkg::DiffWidth'(err_raw);
      db_pos    = $signed(pdc_pkg::DiffWidth'(cfg.deadband_width));
      db_neg    = -db_pos;
      ref_wide  = pdc_pkg::DiffWidth'(req_ch.reference);
      prev_wide = pdc_pkg::DiffWidth'(prev_err_ff);

      above         = err_wide > db_pos;
      below         = err_wide < db_neg;
      in_band       = cfg.deadband_enable && !above && !below;
      ref_in_band   = (ref_wide < db_pos) && (ref_wide > db_neg);
      prev_out_band = (prev_wide < db_neg) || (prev_wide > db_pos);

      if (cfg.deadband_enable && above) begin
         err_adj = err_wide - db_pos;
      end else if (cfg.deadband_enable && below) begin
         err_adj = err_wide + db_pos;
      end else begin
         err_adj = err_wide;
      end
      err_new  = err_adj[pdc_pkg::ErrWidth-1:0];
      err_diff = pdc_pkg::DiffWidth'(err_new) - prev_wide;

      p_prod = cfg.prop_gain * err_adj;
      i_prod = cfg.integ_gain * err_adj;
      d_prod = cfg.deriv_gain * err_diff;

      s1_in.p_term = p_prod[pdc_pkg::ProdWidth-1:pdc_pkg::GainFracBits];
      s1_in.i_term = i_prod[pdc_pkg::ProdWidth-1:pdc_pkg::GainFracBits];
      s1_in.d_term = d_prod[pdc_pkg::ProdWidth-1:pdc_pkg::GainFracBits];

      if (req_ch.op == pdc_pkg::OP_CLEAR) begin
         s1_in.clear_integ = 1'b1;
         s1_in.zero_out    = 1'b1;
         prev_err_in       = '0;
      end else begin
         s1_in.clear_integ = in_band && ref_in_band && prev_out_band;
         s1_in.zero_out    = in_band && cfg.zero_in_band;
         prev_err_in       = err_new;
      end

      s1_valid_in = accept || (s1_valid_ff && !stage_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         prev_err_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            prev_err_ff <= prev_err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == pdc_pkg::OP_CLEAR |=> prev_err_ff == '0)
      else $error("previous error not cleared by a clear item");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not enter the gain stage");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.op == pdc_pkg::OP_CLEAR |=> s1_ff.zero_out && s1_ff.clear_integ)
      else $error("clear item not flagged in the gain stage");

endmodule

/* src/pdc_back.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: integrator and output stage
// Updates and clamps the integrator, sums the terms, clamps the drive (or zeroes
// it for a zeroed item) and holds it in the result register.
// ----------------------------------------------------------------------------
module pdc_back (
   input  logic                clock,
   input  logic                reset,
   input  pdc_pkg::cfg_type    cfg,
   input  logic                stage_valid,
   input  pdc_pkg::stage_type  stage,
   output logic                stage_ready,
   pdc_rsp_if.source           rsp_ch
);

   function automatic logic signed [pdc_pkg::IntegWidth-1:0] clamp_sym(
      input logic signed [pdc_pkg::SumWidth-1:0] value,
      input logic [pdc_pkg::LimitWidth-1:0]      limit
   );
      logic signed [pdc_pkg::SumWidth-1:0] lim_pos;
      logic signed [pdc_pkg::SumWidth-1:0] lim_neg;
      logic signed [pdc_pkg::SumWidth-1:0] result;
      lim_pos = $signed(pdc_pkg::SumWidth'(limit));
      lim_neg = -lim_pos;
      if (value <= lim_neg) begin
         result = lim_neg;
      end else if (value >= lim_pos) begin
         result = lim_pos;
      end else begin
         result = value;
      end
      return result[pdc_pkg::IntegWidth-1:0];
   endfunction

   logic signed [pdc_pkg::IntegWidth-1:0]  integ_ff;
   logic signed [pdc_pkg::IntegWidth-1:0]  integ_in;
   logic signed [pdc_pkg::SampleWidth-1:0] drive_ff;
   logic signed [pdc_pkg::SampleWidth-1:0] drive_in;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;

   logic                                   take;
   logic signed [pdc_pkg::IntegWidth-1:0]  integ_base;
   logic signed [pdc_pkg::SumWidth-1:0]    integ_sum;
   logic signed [pdc_pkg::IntegWidth-1:0]  integ_clamped;
   logic signed [pdc_pkg::SumWidth-1:0]    drive_sum;

   assign stage_ready  = !out_valid_ff || rsp_ch.ready;
   assign take         = stage_valid && stage_ready;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.drive = drive_ff;

   always_comb begin
      integ_base    = stage.clear_integ ? '0 : integ_ff;
      integ_sum     = pdc_pkg::SumWidth'(integ_base) + pdc_pkg::SumWidth'(stage.i_term);
      integ_clamped = clamp_sym(integ_sum, cfg.integ_limit);
      drive_sum     = pdc_pkg::SumWidth'(stage.p_term) + pdc_pkg::SumWidth'(integ_clamped)
                      + pdc_pkg::SumWidth'(stage.d_term);

      if (stage.zero_out) begin
         integ_in = integ_base;
         drive_in = '0;
      end else begin
         integ_in = integ_clamped;
         drive_in = pdc_pkg::SampleWidth'(clamp_sym(drive_sum, cfg.output_limit));
      end

      out_valid_in = take || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            integ_ff <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         drive_ff <= drive_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("item taken from the gain stage gave no result");

   assert property (@(posedge clock) disable iff (reset)
      take && stage.zero_out |=> drive_ff == '0)
      else $error("zeroed item gave a nonzero drive");

   assert property (@(posedge clock) disable iff (reset)
      take && stage.clear_integ && stage.zero_out |=> integ_ff == '0)
      else $error("integrator not cleared");

endmodule

/* src/pid_controller_deadband_core.sv */
// ----------------------------------------------------------------------------
// PID controller with deadband: top level
// Positional PID step with optional error deadband and symmetric clamps.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   req_ch    in         op, reference, measured
//   rsp_ch    out        drive
//   APB port  in/out     gains, limits and deadband controls
//
// Each item passes a gain stage and then a result register, which holds its
// drive. One item can be accepted every cycle while the response is not stalled.
// While a finished result waits to be taken, an empty gain stage takes a new item.
// A stalled response holds both stages; nothing is dropped or repeated.
// Reset clears the previous error, the integrator and both valid flags at once.
// ----------------------------------------------------------------------------
module pid_controller_deadband_core (
   input  logic                                clock,
   input  logic                                reset,
   pdc_req_if.sink                             req_ch,
   pdc_rsp_if.source                           rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pdc_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [pdc_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [pdc_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                pready
);

   pdc_pkg::cfg_type   cfg;
   pdc_pkg::stage_type stage;
   logic               stage_valid;
   logic               stage_ready;

   pdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .cfg         (cfg),
      .stage_ready (stage_ready),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   pdc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_valid (stage_valid),
      .stage       (stage),
      .stage_ready (stage_ready),
      .rsp_ch      (rsp_ch)
   );

endmodule
